### hdl/pfcc_pkg.sv
package pfcc_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned FLASH_BYTES_DEF = 524288;
  localparam int unsigned LOG_DEPTH_DEF   = 8;

  // Fixed geometry.
  localparam int unsigned SECTOR_BYTES = 16384;
  localparam int unsigned SEC_W        = 14;
  localparam int unsigned PAGE_W       = 5;
  localparam int unsigned BANK_W       = 2;
  localparam int unsigned BUS_ADDR_W   = 16;
  localparam int unsigned LOG_ADDR_W   = PAGE_W + SEC_W;
  localparam int unsigned REG_IDX_W    = 5;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Register window indexes and the banks that enable them.
  localparam logic [REG_IDX_W-1:0] REG_BANK = 5'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAGE = 5'd2;
  localparam logic [REG_IDX_W-1:0] REG_ID0  = 5'd10;
  localparam logic [REG_IDX_W-1:0] REG_ID1  = 5'd11;
  localparam logic [BANK_W-1:0]    BANK_ID  = 2'd0;
  localparam logic [BANK_W-1:0]    BANK_CFG = 2'd3;
  localparam logic [7:0]           ID0_BYTE = 8'h50;
  localparam logic [7:0]           ID1_BYTE = 8'h70;

  // Unlock-sequence command set.
  localparam logic [11:0] CMD_ADDR_A  = 12'hAAA;
  localparam logic [11:0] CMD_ADDR_5  = 12'h555;
  localparam logic [7:0]  CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0]  CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0]  CMD_PROGRAM = 8'hA0;
  localparam logic [7:0]  CMD_ERASE   = 8'h80;
  localparam logic [7:0]  CMD_SECTOR  = 8'h30;
  localparam logic [7:0]  CMD_CHIP    = 8'h10;

  typedef struct packed {
    logic [LOG_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } log_entry_t;

  function automatic logic entry_is(log_entry_t e, logic [11:0] low12, logic [7:0] d);
    return (e.addr[11:0] == low12) && (e.data == d);
  endfunction

endpackage

### hdl/pfcc_ram.sv
module pfcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/paged_flash_command_controller.sv
// Register window and out-of-range reads pass through ST_EXEC and ST_RESP, then the result
// is registered on the output. A flash read folds the paged address into the array by passes
// of the shared subtract unit, then one registered RAM read; a program folds it the same way,
// then writes the old byte ANDed with the write data. Sector and chip erase hold the block busy
// sweeping the sector or the whole array, one RAM write per cycle. After reset the block sweeps
// the whole array to 0xFF (input not ready); bank, page and command count reset to zero.
module paged_flash_command_controller #(
  parameter int unsigned FLASH_BYTES = pfcc_pkg::FLASH_BYTES_DEF,
  parameter int unsigned LOG_DEPTH   = pfcc_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_data
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] read_data
);
  import pfcc_pkg::*;

  localparam int unsigned FA_W  = $clog2(FLASH_BYTES);
  localparam int unsigned SW_W  = FA_W + 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(LOG_DEPTH);
  localparam logic [LOG_ADDR_W:0] FlashSize = (LOG_ADDR_W + 1)'(FLASH_BYTES);
  localparam logic [SW_W-1:0]     FlashEnd  = SW_W'(FLASH_BYTES);
  localparam logic [SW_W-1:0]     SectSize  = SW_W'(SECTOR_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_WRAP, ST_RDWAIT, ST_PRGWR, ST_RESP, ST_SWEEP
  } state_e;

  typedef enum logic [1:0] {
    OP_READ, OP_PROG, OP_SECT
  } op_e;

  state_e                state_q;
  op_e                   op_q;
  logic                  item_func_q;
  logic [BUS_ADDR_W-1:0] item_addr_q;
  logic [7:0]            item_data_q;
  logic [LOG_ADDR_W-1:0] wa_q;
  logic [SW_W-1:0]       sw_q;
  logic [SW_W-1:0]       sw_end_q;
  logic [7:0]            res_q;
  logic                  m_valid_q;
  logic [7:0]            m_data_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [PAGE_W-1:0]     page_q;
  logic [BANK_W-1:0]     bank_q;
  log_entry_t            log_q [LOG_DEPTH];

  logic                  ram_en;
  logic                  ram_we;
  logic [FA_W-1:0]       ram_addr;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;

  logic                  in_reg_win;
  logic                  in_flash;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [7:0]            reg_rd;
  logic [LOG_ADDR_W-1:0] faddr;
  logic                  log_room;
  logic                  log_wr;
  logic                  prog_hit;
  logic                  erase_hit;
  logic                  sect_hit;
  logic                  chip_hit;
  logic [LOG_ADDR_W:0]   wa_ext;
  logic                  wrap_over;
  logic [SW_W-1:0]       sect_base;
  logic [SW_W-1:0]       sect_top;
  logic [SW_W-1:0]       sw_next;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Decode of the captured item.
  assign in_reg_win = &item_addr_q[13:5];
  assign in_flash   = !in_reg_win && (item_addr_q[15:14] == 2'b00);
  assign reg_idx    = item_addr_q[REG_IDX_W-1:0];
  assign faddr      = {page_q, item_addr_q[SEC_W-1:0]};

  always_comb begin
    reg_rd = ERASED_BYTE;
    if (reg_idx == REG_BANK) begin
      reg_rd = {bank_q, 6'd0};
    end else if (reg_idx == REG_PAGE && bank_q == BANK_CFG) begin
      reg_rd = {(8 - PAGE_W)'(0), page_q};
    end else if (reg_idx == REG_ID0 && bank_q == BANK_ID) begin
      reg_rd = ID0_BYTE;
    end else if (reg_idx == REG_ID1 && bank_q == BANK_ID) begin
      reg_rd = ID1_BYTE;
    end
  end

  // The new entry lands at index cnt_q, so the older entries are checked as stored.
  assign log_room  = cnt_q < CNT_W'(LOG_DEPTH);
  assign log_wr    = (state_q == ST_EXEC) && in_flash && item_func_q && log_room;
  assign prog_hit  = (cnt_q == CNT_W'(3)) &&
                     entry_is(log_q[0], CMD_ADDR_A, CMD_UNLOCK1) &&
                     entry_is(log_q[1], CMD_ADDR_5, CMD_UNLOCK2) &&
                     entry_is(log_q[2], CMD_ADDR_A, CMD_PROGRAM);
  assign erase_hit = (cnt_q == CNT_W'(5)) &&
                     entry_is(log_q[0], CMD_ADDR_A, CMD_UNLOCK1) &&
                     entry_is(log_q[1], CMD_ADDR_5, CMD_UNLOCK2) &&
                     entry_is(log_q[2], CMD_ADDR_A, CMD_ERASE) &&
                     entry_is(log_q[3], CMD_ADDR_A, CMD_UNLOCK1) &&
                     entry_is(log_q[4], CMD_ADDR_5, CMD_UNLOCK2);
  assign sect_hit  = erase_hit && (item_data_q == CMD_SECTOR);
  assign chip_hit  = erase_hit && (item_data_q == CMD_CHIP);

  // Shared compare-and-subtract unit folds the paged address into the array.
  assign wa_ext    = {1'b0, wa_q};
  assign wrap_over = wa_ext >= FlashSize;
  assign sect_base = {1'b0, wa_q[FA_W-1:SEC_W], SEC_W'(0)};
  assign sect_top  = ((sect_base + SectSize) > FlashEnd) ? FlashEnd : (sect_base + SectSize);
  assign sw_next   = sw_q + SW_W'(1);

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = wa_q[FA_W-1:0];
    ram_wdata = ERASED_BYTE;
    unique case (state_q)
      ST_SWEEP: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = sw_q[FA_W-1:0];
      end
      ST_WRAP: begin
        ram_en = !wrap_over && (op_q == OP_READ || op_q == OP_PROG);
      end
      ST_PRGWR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & item_data_q;
      end
      default: begin
      end
    endcase
  end

  pfcc_ram #(
    .WIDTH (8),
    .DEPTH (FLASH_BYTES)
  ) u_flash (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (log_wr) begin
      log_q[cnt_q[IDX_W-1:0]] <= '{addr: faddr, data: item_data_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      op_q        <= OP_READ;
      item_func_q <= 1'b0;
      item_addr_q <= '0;
      item_data_q <= '0;
      wa_q        <= '0;
      sw_q        <= '0;
      sw_end_q    <= FlashEnd;
      res_q       <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      cnt_q       <= '0;
      page_q      <= '0;
      bank_q      <= '0;
    end else begin
      // In ST_RESP the output register is handled by the state itself.
      if (m_valid_q && m_axis_tready && state_q != ST_RESP) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            item_func_q <= s_axis_tuser;
            item_addr_q <= s_axis_tdata[15:0];
            item_data_q <= s_axis_tdata[23:16];
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (in_reg_win) begin
            if (item_func_q) begin
              if (reg_idx == REG_BANK) begin
                bank_q <= item_data_q[7:6];
              end else if (reg_idx == REG_PAGE && bank_q == BANK_CFG) begin
                page_q <= item_data_q[PAGE_W-1:0];
              end
              state_q <= ST_IDLE;
            end else begin
              res_q   <= reg_rd;
              state_q <= ST_RESP;
            end
          end else if (in_flash) begin
            if (!item_func_q) begin
              wa_q    <= faddr;
              op_q    <= OP_READ;
              state_q <= ST_WRAP;
            end else if (!log_room) begin
              state_q <= ST_IDLE;
            end else if (prog_hit) begin
              cnt_q   <= '0;
              wa_q    <= faddr;
              op_q    <= OP_PROG;
              state_q <= ST_WRAP;
            end else if (sect_hit) begin
              cnt_q   <= '0;
              wa_q    <= faddr;
              op_q    <= OP_SECT;
              state_q <= ST_WRAP;
            end else if (chip_hit) begin
              cnt_q    <= '0;
              sw_q     <= '0;
              sw_end_q <= FlashEnd;
              state_q  <= ST_SWEEP;
            end else begin
              cnt_q   <= cnt_q + CNT_W'(1);
              state_q <= ST_IDLE;
            end
          end else if (item_func_q) begin
            state_q <= ST_IDLE;
          end else begin
            res_q   <= ERASED_BYTE;
            state_q <= ST_RESP;
          end
        end
        ST_WRAP: begin
          if (wrap_over) begin
            wa_q <= LOG_ADDR_W'(wa_ext - FlashSize);
          end else begin
            case (op_q)
              OP_READ: state_q <= ST_RDWAIT;
              OP_PROG: state_q <= ST_PRGWR;
              default: begin
                sw_q     <= sect_base;
                sw_end_q <= sect_top;
                state_q  <= ST_SWEEP;
              end
            endcase
          end
        end
        ST_RDWAIT: begin
          res_q   <= ram_rdata;
          state_q <= ST_RESP;
        end
        ST_PRGWR: begin
          state_q <= ST_IDLE;
        end
        ST_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= res_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          sw_q <= sw_next;
          if (sw_next == sw_end_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LOG_DEPTH))
    else $error("command count beyond log depth");

  a_ram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_en |-> ({1'b0, ram_addr} < FlashEnd))
    else $error("flash access outside the array");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (sw_q < sw_end_q))
    else $error("erase sweep ran past its end");

  a_page_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(page_q) |-> $past(state_q == ST_EXEC && item_func_q && in_reg_win))
    else $error("page select changed without a register write");

endmodule
